[design/ptc_pkg.sv]
// package: kinds, error codes, transaction structs and helpers for the type converter
package ptc_pkg;

    localparam logic [1:0] KIND_FLOAT = 2'd0;
    localparam logic [1:0] KIND_UINT  = 2'd1;
    localparam logic [1:0] KIND_INT   = 2'd2;
    localparam logic [1:0] KIND_BOOL  = 2'd3;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_TO_FLOAT = 3'd1;
    localparam logic [2:0] ERR_TO_UINT  = 3'd2;
    localparam logic [2:0] ERR_TO_INT   = 3'd3;
    localparam logic [2:0] ERR_TO_BOOL  = 3'd4;

    localparam logic [31:0] MANT_MASK = 32'h007F_FFFF;
    localparam logic [31:0] NAN_FORCE = 32'h0040_0000;
    localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

    localparam int unsigned PIPE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  src_kind;
        logic [31:0] src_bits;
        logic [1:0]  dst_kind;
        logic [6:0]  dst_precision;
    } t_in;

    typedef struct packed {
        logic [31:0] result_bits;
        logic [2:0]  error_code;
    } t_out;

    // round off the low cut mantissa bits, first zero at or above the cut absorbs the carry
    function automatic logic [31:0] cut_mantissa(input logic [31:0] x, input logic [4:0] cut);
        logic [31:0] v;
        logic [4:0]  c;
        logic        done;
        v    = x;
        c    = cut;
        done = 1'b0;
        if (cut != 5'd0 && x[cut - 5'd1]) begin
            for (int i = 0; i < 23; i++) begin
                if (!done && i >= int'(cut) && !x[i]) begin
                    v[i] = 1'b1;
                    c    = 5'(i);
                    done = 1'b1;
                end
            end
        end
        return v & ((32'hFFFF_FFFF >> c) << c);
    endfunction

endpackage

[design/ptc_narrow.sv]
// two-stage fp16 narrowing of a 32-bit float pattern: classify, then round
module ptc_narrow (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_x,
    output logic [31:0] o_x
);
    import ptc_pkg::*;

    logic [7:0]  w_e;
    logic [31:0] n_x, r_x;
    logic [4:0]  n_cut, r_cut;
    logic        n_pass, r_pass;
    logic [7:0]  w_d;

    assign w_e = i_x[30:23];
    assign w_d = 8'd113 - w_e;

    // classify the exponent and choose the cut point
    always_comb begin
        n_x    = i_x;
        n_cut  = 5'd13;
        n_pass = 1'b0;
        if (w_e[7]) begin
            if (w_e >= 8'h8F) begin
                n_pass = 1'b1;
                if (w_e == 8'hFF) begin
                    if ((i_x & MANT_MASK) != 32'd0) n_x = i_x | NAN_FORCE;
                end else begin
                    n_x = (i_x & SIGN_BIT) | INF_BITS;
                end
            end
        end else if (w_e[6:4] == 3'b111 && w_e[3:0] != 4'd0) begin
            n_cut = 5'd13;
        end else if (w_e <= 8'h65) begin
            n_pass = 1'b1;
            n_x    = 32'd0;
        end else begin
            n_cut = (w_d > 8'd10) ? 5'd23 : 5'(w_d + 8'd13);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_cut  <= n_cut;
            r_pass <= n_pass;
        end
    end

    // rounding
    assign o_x = r_pass ? r_x : cut_mantissa(r_x, r_cut);
endmodule

[design/primitive_type_converter.sv]
// top level: four-stage pipelined primitive type converter
//
//  channel | signals                     | payload
//  in      | i_in_valid / o_in_ready     | i_in  (t_in)
//  out     | o_out_valid / i_out_ready   | o_out (t_out)
//
// one transaction per cycle while the output does not stall; the stages are
// leading-one detect, shift and round, narrow classify, narrow round. the whole
// pipeline advances only when the output register is free or being taken, so a
// stall holds every stage. reset clears the stage valid bits only.
module primitive_type_converter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ptc_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ptc_pkg::t_out  o_out
);
    import ptc_pkg::*;

    logic [PIPE_DEPTH-1:0] r_v;
    logic                  w_adv;

    assign w_adv      = !r_v[PIPE_DEPTH-1] || i_out_ready;
    assign o_in_ready = w_adv;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    // stage 1: decode, magnitude, leading one
    logic [31:0] n_mag, r1_mag, r1_pass;
    logic        n_sign, r1_sign, n_toflt, r1_toflt, r1_narrow, n_narrow;
    logic [4:0]  n_p, r1_p;
    logic [2:0]  n_err, r1_err;
    logic [31:0] n_res;

    always_comb begin
        n_mag    = i_in.src_bits;
        n_sign   = 1'b0;
        n_toflt  = 1'b0;
        n_err    = ERR_OK;
        n_res    = 32'd0;
        n_narrow = 1'b0;
        n_p      = 5'd0;
        case (i_in.dst_kind)
            KIND_FLOAT: begin
                n_narrow = (i_in.dst_precision != 7'd32) && (i_in.dst_precision <= 7'd16);
                case (i_in.src_kind)
                    KIND_FLOAT: n_res = i_in.src_bits;
                    KIND_UINT:  n_toflt = 1'b1;
                    KIND_INT: begin
                        n_toflt = 1'b1;
                        n_sign  = i_in.src_bits[31];
                        if (n_sign) n_mag = 32'd0 - i_in.src_bits;
                    end
                    default: begin
                        n_err    = ERR_TO_FLOAT;
                        n_narrow = 1'b0;
                    end
                endcase
            end
            KIND_UINT: begin
                if (i_in.src_kind == KIND_UINT) begin
                    n_res = i_in.src_bits;
                    if (i_in.dst_precision < 7'd32)
                        n_res = i_in.src_bits & ((32'd1 << i_in.dst_precision[4:0]) - 32'd1);
                end else begin
                    n_err = ERR_TO_UINT;
                end
            end
            KIND_INT: begin
                if (i_in.src_kind inside {KIND_UINT, KIND_INT}) n_res = i_in.src_bits;
                else n_err = ERR_TO_INT;
            end
            default: begin
                if (i_in.src_kind inside {KIND_BOOL, KIND_UINT})
                    n_res = {31'd0, i_in.src_bits != 32'd0};
                else n_err = ERR_TO_BOOL;
            end
        endcase
        for (int i = 0; i < 32; i++) begin
            if (n_mag[i]) n_p = 5'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_mag    <= n_mag;
            r1_sign   <= n_sign;
            r1_toflt  <= n_toflt;
            r1_err    <= n_err;
            r1_pass   <= n_res;
            r1_narrow <= n_narrow;
            r1_p      <= n_p;
        end
    end

    // stage 2: normalize and round to nearest even
    logic [31:0] n2_res, r2_res;
    logic [2:0]  r2_err;
    logic        r2_narrow;
    logic [31:0] w_q, w_rem, w_half;
    logic [4:0]  w_s;
    logic [7:0]  w_exp;

    always_comb begin
        w_s    = 5'd0;
        w_rem  = 32'd0;
        w_half = 32'd0;
        w_exp  = 8'd127 + {3'd0, r1_p};
        if (r1_p <= 5'd23) begin
            w_q = r1_mag << (5'd23 - r1_p);
        end else begin
            w_s    = r1_p - 5'd23;
            w_rem  = r1_mag & ((32'd1 << w_s) - 32'd1);
            w_half = 32'd1 << (w_s - 5'd1);
            w_q    = r1_mag >> w_s;
            if (w_rem > w_half || (w_rem == w_half && w_q[0])) w_q = w_q + 32'd1;
            if (w_q[24]) begin
                w_q   = w_q >> 1;
                w_exp = w_exp + 8'd1;
            end
        end
        if (!r1_toflt) n2_res = r1_pass;
        else if (r1_mag == 32'd0) n2_res = 32'd0;
        else n2_res = {r1_sign, w_exp, w_q[22:0]};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_res    <= n2_res;
            r2_err    <= r1_err;
            r2_narrow <= r1_narrow;
        end
    end

    // stages 3 and 4: fp16 narrowing
    logic [31:0] w_nar, r3_res;
    logic [2:0]  r3_err, r4_err;
    logic        r3_narrow;
    logic [31:0] r4_res;

    ptc_narrow u_narrow (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_x   (r2_res),
        .o_x   (w_nar)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_res    <= r2_res;
            r3_err    <= r2_err;
            r3_narrow <= r2_narrow;
            r4_res    <= r3_narrow ? w_nar : r3_res;
            r4_err    <= r3_err;
        end
    end

    assign o_out_valid       = r_v[PIPE_DEPTH-1];
    assign o_out.result_bits = r4_res;
    assign o_out.error_code  = r4_err;
endmodule
